// ===== design/wpm_pkg.sv =====
// Package for the wildcard pattern matcher.
// Holds the register map, the pattern byte codes and the types shared by the cell row.
// No dependencies.
package wpm_pkg;

   localparam int DEF_MAX_PATTERN = 32;
   localparam int NUM_CHAR_REGS = 4;
   localparam int CHARS_PER_REG = 8;
   localparam int LEN_W = 6;
   localparam int CHAR_W = 8;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_CHARS_0 = 3'd1;

   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
   localparam logic [CHAR_W-1:0] ANY_CHAR = 8'h3F;

   // Control shared by every cell of the row.
   typedef struct packed {
      logic advance;
      logic restart;
   } cell_ctl_type;

   // Signals one cell hands to the next position.
   typedef struct packed {
      logic cls;   // star closure of the current set into the next position
      logic adv;   // byte match moves into the next position
      logic ncls;  // star closure of the new set into the next position
   } link_type;

endpackage

// ===== design/wpm_cell.sv =====
// One pattern position of the matcher: holds its active bit and forms the closure and step.
// Depends on wpm_pkg.
module wpm_cell import wpm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic              start_pos,
   input  logic              in_use,
   input  logic              keep,
   input  logic [CHAR_W-1:0] pat_char,
   input  logic [CHAR_W-1:0] name_char,
   input  link_type          link_in,
   output link_type          link_out,
   output logic              next_bit,
   output logic              active
);

   logic active_ff;
   logic active_in;
   logic closed;
   logic is_star;
   logic hit;
   logic raw_next;

   always_comb begin
      is_star = (pat_char == STAR_CHAR);
      hit = (pat_char == ANY_CHAR) || (pat_char == name_char);
      // Bits above the pattern length are dropped before the closure.
      closed = (active_ff & keep) | link_in.cls;
      link_out.cls = closed & is_star & in_use;
      link_out.adv = closed & in_use & ~is_star & hit;
      raw_next = (closed & in_use & is_star) | link_in.adv;
      next_bit = (raw_next | link_in.ncls) & keep;
      link_out.ncls = next_bit & is_star & in_use;
      active_in = ctl.restart ? start_pos : next_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= start_pos;
      end else if (ctl.advance) begin
         active_ff <= active_in;
      end
   end

   assign active = active_ff;

endmodule

// ===== design/wpm_out_buf.sv =====
// Two-entry result buffer: an output register with a skid slot behind it.
// Depends on wpm_pkg only for the house import.
module wpm_out_buf import wpm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic push_data,
   output logic full,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_data
);

   logic head_valid_ff, head_valid_in;
   logic head_data_ff, head_data_in;
   logic skid_valid_ff, skid_valid_in;
   logic skid_data_ff, skid_data_in;
   logic pop;

   always_comb begin
      pop = head_valid_ff & ~rsp_stall;
      head_valid_in = head_valid_ff;
      head_data_in = head_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_data_in = skid_data_ff;
            skid_valid_in = push;
            skid_data_in = push_data;
         end else begin
            head_valid_in = push;
            head_data_in = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_data_ff <= head_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_data = head_data_ff;

endmodule

// ===== design/wildcard_pattern_matcher_top.sv =====
// Wildcard pattern matcher, top level: pattern registers, the row of position cells and
// the result buffer. Depends on wpm_pkg, wpm_cell and wpm_out_buf.
// Throughput: one name byte per cycle while the input is not stalled; the star closure
// rippling through the cell row sets the cycle time. The match flag for the last byte is
// registered in the result buffer. Input stalls only while two results wait at the output.
// Reset (synchronous): pattern length and bytes cleared, only position zero active, no results.
module wildcard_pattern_matcher_top import wpm_pkg::*; #(
   parameter int MAX_PATTERN = DEF_MAX_PATTERN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_name_char,
   input  logic                  req_last_char,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_matched,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int UL_W = $clog2(MAX_PATTERN + 1);
   localparam int CMP_W = ((UL_W > LEN_W) ? UL_W : LEN_W) + 1;
   localparam int REG_BYTES = NUM_CHAR_REGS * CHARS_PER_REG;
   localparam logic [MAX_PATTERN:0] START_VEC = {{MAX_PATTERN{1'b0}}, 1'b1};

   logic [LEN_W-1:0]  pattern_length_ff;
   logic [CMP_W-1:0]  len_ext;
   logic [CHAR_W-1:0] pat_byte [MAX_PATTERN+1];
   link_type          links [MAX_PATTERN+2];
   logic [MAX_PATTERN:0] next_vec;
   logic [MAX_PATTERN:0] active_vec;
   logic [MAX_PATTERN:0] sel_vec;
   cell_ctl_type      ctl;
   logic              accept;
   logic              matched;
   logic              buf_full;

   assign accept = req_valid & ~req_stall;
   assign ctl.advance = accept;
   assign ctl.restart = accept & req_last_char;
   assign len_ext = CMP_W'(pattern_length_ff);
   assign links[0] = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
      end else if (csr_we && csr_index == REG_PATTERN_LENGTH) begin
         pattern_length_ff <= csr_wdata[LEN_W-1:0];
      end
   end

   for (genvar p = 0; p <= MAX_PATTERN; p++) begin : g_pos
      localparam logic [CMP_W-1:0] POS = CMP_W'(p);
      logic in_use;
      logic keep;

      if (p < MAX_PATTERN && p < REG_BYTES) begin : g_byte
         localparam logic [CSR_IDX_W-1:0] REG_IDX =
            CSR_IDX_W'(int'(REG_PATTERN_CHARS_0) + p / CHARS_PER_REG);
         localparam int BYTE_LSB = (p % CHARS_PER_REG) * CHAR_W;
         logic [CHAR_W-1:0] pat_byte_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               pat_byte_ff <= '0;
            end else if (csr_we && csr_index == REG_IDX) begin
               pat_byte_ff <= csr_wdata[BYTE_LSB +: CHAR_W];
            end
         end
         assign pat_byte[p] = pat_byte_ff;
      end else begin : g_zero
         // Positions past the character registers, and the final position, hold no byte.
         assign pat_byte[p] = '0;
      end

      if (p < MAX_PATTERN) begin : g_used
         assign in_use = (POS < len_ext);
      end else begin : g_tail
         assign in_use = 1'b0;
      end
      assign keep = (POS <= len_ext);

      // A length above the row clamps to the final position.
      if (p == MAX_PATTERN) begin : g_sel_tail
         assign sel_vec[p] = (POS <= len_ext);
      end else begin : g_sel
         assign sel_vec[p] = (POS == len_ext);
      end

      wpm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .start_pos (START_VEC[p]),
         .in_use    (in_use),
         .keep      (keep),
         .pat_char  (pat_byte[p]),
         .name_char (req_name_char),
         .link_in   (links[p]),
         .link_out  (links[p+1]),
         .next_bit  (next_vec[p]),
         .active    (active_vec[p])
      );
   end

   assign matched = |(next_vec & sel_vec);

   wpm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (ctl.restart),
      .push_data (matched),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_matched)
   );

   assign req_stall = buf_full;

`ifndef NO_ASSERTIONS
   a_restart_state: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_char) |=> (active_vec == START_VEC))
      else $error("active set not back at the start state after a last item");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_char) |=> rsp_valid)
      else $error("no result shown after a last item");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");
`endif

endmodule
